[hdl/ising_pkg.sv]
package ising_pkg;

    localparam int COORD_W = 7;
    localparam int DRAW_W  = 16;
    localparam int THR_W   = 17;
    localparam int MAG_W   = 16;
    localparam int E_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic [DRAW_W-1:0]        draw_t;
    typedef logic [THR_W-1:0]         thr_t;
    typedef logic signed [MAG_W-1:0]  mag_t;
    typedef logic signed [E_W-1:0]    energy_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    localparam cfg_idx_t CFG_THR_ZERO = 2'd0;
    localparam cfg_idx_t CFG_THR_TWO  = 2'd1;
    localparam cfg_idx_t CFG_THR_FOUR = 2'd2;

    localparam thr_t THR_ZERO_RST = 17'd65536;
    localparam thr_t THR_TWO_RST  = 17'd53656;
    localparam thr_t THR_FOUR_RST = 17'd43930;

    typedef struct packed {
        logic   op;
        coord_t row;
        coord_t col;
        draw_t  random_draw;
        logic   spin_value;
    } item_t;

    typedef struct packed {
        logic    flipped;
        logic    spin_after;
        energy_t energy_change;
        mag_t    magnetization;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_SITE,
        ST_RD_ABOVE,
        ST_RD_BELOW,
        ST_EVAL
    } state_t;

    typedef enum logic [1:0] {
        RD_SITE,
        RD_ABOVE,
        RD_BELOW
    } rd_sel_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_row;
        logic    cap_above;
        logic    commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic trial;
    } dp_stat_t;

endpackage

[hdl/ising_ctrl.sv]
module ising_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ising_pkg::dp_stat_t stat,
    output logic               busy,
    output ising_pkg::dp_cmd_t  cmd
);

    ising_pkg::state_t state_reg;
    ising_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ising_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        busy          = 1'b1;
        cmd           = '0;
        cmd.rd_sel    = ising_pkg::RD_SITE;
        case (state_reg)
            ising_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ising_pkg::ST_IDLE;
                end
            end
            ising_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ising_pkg::ST_RD_SITE;
                end
            end
            ising_pkg::ST_RD_SITE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ising_pkg::RD_SITE;
                state_next = ising_pkg::ST_RD_ABOVE;
            end
            ising_pkg::ST_RD_ABOVE:
            begin
                cmd.cap_row = 1'b1;
                if (stat.trial)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ising_pkg::RD_ABOVE;
                    state_next = ising_pkg::ST_RD_BELOW;
                end
                else
                begin
                    state_next = ising_pkg::ST_EVAL;
                end
            end
            ising_pkg::ST_RD_BELOW:
            begin
                cmd.cap_above = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = ising_pkg::RD_BELOW;
                state_next    = ising_pkg::ST_EVAL;
            end
            ising_pkg::ST_EVAL:
            begin
                cmd.commit = 1'b1;
                state_next = ising_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ising_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

[hdl/ising_dp.sv]
module ising_dp #(
    parameter int SIDE = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ising_pkg::item_t      item,
    input  ising_pkg::dp_cmd_t    cmd,
    output ising_pkg::dp_stat_t   stat,
    input  logic                  cfg_write,
    input  ising_pkg::cfg_idx_t   cfg_index,
    input  ising_pkg::thr_t       cfg_data,
    output logic                  done,
    output ising_pkg::result_t    result
);

    localparam int IDX_W   = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int IN_SPAN = 2 ** ising_pkg::COORD_W;

    // coordinate reduction modulo SIDE
    logic [IDX_W-1:0] red_tab [IN_SPAN];
    for (genvar i = 0; i < IN_SPAN; i++)
    begin : g_red
        assign red_tab[i] = IDX_W'(i % SIDE);
    end

    logic [SIDE-1:0] lattice_mem [SIDE];
    logic [SIDE-1:0] rd_data_reg;
    logic [SIDE-1:0] row_cur_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic             op_reg;
    ising_pkg::draw_t draw_reg;
    logic             wval_reg;
    logic             above_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    ising_pkg::mag_t  mag_reg;
    ising_pkg::thr_t  thr_zero_reg;
    ising_pkg::thr_t  thr_two_reg;
    ising_pkg::thr_t  thr_four_reg;
    logic             done_reg;
    ising_pkg::result_t result_reg;

    logic [IDX_W-1:0] row_up;
    logic [IDX_W-1:0] row_dn;
    logic [IDX_W-1:0] col_up;
    logic [IDX_W-1:0] col_dn;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [SIDE-1:0]  mem_wdata;
    logic [SIDE-1:0]  row_new;

    logic             old_spin;
    logic [2:0]       ups;
    ising_pkg::energy_t nsum;
    ising_pkg::energy_t e_trial;
    ising_pkg::thr_t  thr_sel;
    logic             accept;
    logic             spin_new;
    ising_pkg::mag_t  mag_next;
    ising_pkg::result_t result_next;

    assign row_up = (row_reg == '0) ? IDX_W'(SIDE - 1) : row_reg - IDX_W'(1);
    assign row_dn = (row_reg == IDX_W'(SIDE - 1)) ? '0 : row_reg + IDX_W'(1);
    assign col_up = (col_reg == IDX_W'(SIDE - 1)) ? '0 : col_reg + IDX_W'(1);
    assign col_dn = (col_reg == '0) ? IDX_W'(SIDE - 1) : col_reg - IDX_W'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            ising_pkg::RD_SITE:  rd_addr = row_reg;
            ising_pkg::RD_ABOVE: rd_addr = row_up;
            ising_pkg::RD_BELOW: rd_addr = row_dn;
            default:             rd_addr = row_reg;
        endcase
    end

    // evaluation: below-row arrives in rd_data_reg during commit
    assign old_spin = row_cur_reg[col_reg];
    assign ups = {2'b00, row_cur_reg[col_up]} + {2'b00, row_cur_reg[col_dn]}
               + {2'b00, above_reg} + {2'b00, rd_data_reg[col_reg]};
    assign nsum    = ising_pkg::energy_t'({1'b0, ups} << 1) - ising_pkg::energy_t'(4);
    assign e_trial = old_spin ? nsum : -nsum;

    always_comb
    begin
        case (e_trial)
            ising_pkg::energy_t'(0): thr_sel = thr_zero_reg;
            ising_pkg::energy_t'(2): thr_sel = thr_two_reg;
            default:                 thr_sel = thr_four_reg;
        endcase
    end

    assign accept   = e_trial[ising_pkg::E_W-1]
                    || ({1'b0, draw_reg} < thr_sel);
    assign spin_new = (op_reg == ising_pkg::OP_TRIAL) ? (old_spin ^ accept) : wval_reg;

    always_comb
    begin
        mag_next = mag_reg;
        if (spin_new != old_spin)
        begin
            mag_next = spin_new ? (mag_reg + ising_pkg::mag_t'(2))
                                : (mag_reg - ising_pkg::mag_t'(2));
        end
    end

    always_comb
    begin
        row_new          = row_cur_reg;
        row_new[col_reg] = spin_new;
    end

    always_comb
    begin
        result_next.flipped       = (op_reg == ising_pkg::OP_TRIAL) && accept;
        result_next.spin_after    = spin_new;
        result_next.energy_change = (op_reg == ising_pkg::OP_TRIAL) ? e_trial : '0;
        result_next.magnetization = mag_next;
    end

    assign mem_we    = cmd.clear || cmd.commit;
    assign mem_waddr = cmd.clear ? clr_cnt_reg : row_reg;
    assign mem_wdata = cmd.clear ? '1 : row_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= lattice_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= item.op;
            row_reg  <= red_tab[item.row];
            col_reg  <= red_tab[item.col];
            draw_reg <= item.random_draw;
            wval_reg <= item.spin_value;
        end
        if (cmd.cap_row)
        begin
            row_cur_reg <= rd_data_reg;
        end
        if (cmd.cap_above)
        begin
            above_reg <= rd_data_reg[col_reg];
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            mag_reg      <= ising_pkg::mag_t'(SIDE * SIDE);
            thr_zero_reg <= ising_pkg::THR_ZERO_RST;
            thr_two_reg  <= ising_pkg::THR_TWO_RST;
            thr_four_reg <= ising_pkg::THR_FOUR_RST;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.commit)
            begin
                mag_reg <= mag_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    ising_pkg::CFG_THR_ZERO: thr_zero_reg <= cfg_data;
                    ising_pkg::CFG_THR_TWO:  thr_two_reg  <= cfg_data;
                    ising_pkg::CFG_THR_FOUR: thr_four_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == IDX_W'(SIDE - 1));
    assign stat.trial      = (op_reg == ising_pkg::OP_TRIAL);
    assign done            = done_reg;
    assign result          = result_reg;

endmodule

[hdl/ising_metropolis_spin_update.sv]
// channel   | transfer when           | payload
// ----------+-------------------------+-------------------------------------
// item in   | start && !busy          | item   (op, row, col, draw, spin)
// result    | done, one cycle         | result (flipped, spin, dE, magnet.)
// config    | cfg_write               | cfg_index, cfg_data
//
// Write item: busy until its row is written back, done once idle again.
// Trial item: busy for three row reads and a write-back on the one lattice
// RAM port, done once idle again; a new start is taken in the done cycle.
// After reset a clearing pass sets every row up and is busy until it ends.
// The result receiver cannot stall; done is a single-cycle strobe.
module ising_metropolis_spin_update #(
    parameter int SIDE = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ising_pkg::item_t    item,
    output logic                done,
    output ising_pkg::result_t  result,
    input  logic                cfg_write,
    input  ising_pkg::cfg_idx_t cfg_index,
    input  ising_pkg::thr_t     cfg_data
);

    ising_pkg::dp_cmd_t  cmd;
    ising_pkg::dp_stat_t stat;

    ising_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    ising_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobed twice");

    a_write_no_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !stat.trial) |-> (!result.flipped && result.energy_change == '0))
        else $error("spin write reported a flip or energy change");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int SIDE = 128;
    localparam int CELLS = SIDE * SIDE;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT = 100;
    localparam int PHASE_ITEMS = 150;
    localparam int RANDOM_PHASES = 5;
    localparam ising_pkg::cfg_idx_t CFG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    ising_pkg::item_t       item;
    logic                   done;
    ising_pkg::result_t     result;
    logic                   cfg_write;
    ising_pkg::cfg_idx_t    cfg_index;
    ising_pkg::thr_t        cfg_data;

    bit                     spin_up [CELLS];
    int                     magnet;
    ising_pkg::thr_t        thr_zero;
    ising_pkg::thr_t        thr_two;
    ising_pkg::thr_t        thr_four;
    ising_pkg::result_t     expected_q [$];
    int                     errors = 0;
    int                     idle_cycles = 0;
    bit                     start_high = 0;
    int                     burst_left = 0;
    ising_pkg::coord_t      win_r;
    ising_pkg::coord_t      win_c;

    always #10 clk = ~clk;

    ising_metropolis_spin_update #(
        .SIDE(SIDE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic int spin_at(int r, int c);
        return spin_up[r * SIDE + c] ? 1 : -1;
    endfunction

    function automatic ising_pkg::result_t predict_update(ising_pkg::item_t it);
        int                 r;
        int                 c;
        int                 idx;
        int                 old;
        int                 s;
        int                 e;
        bit                 accept;
        ising_pkg::thr_t    th;
        ising_pkg::result_t res;
        r = int'(it.row) % SIDE;
        c = int'(it.col) % SIDE;
        idx = r * SIDE + c;
        old = spin_at(r, c);
        accept = 1'b0;
        e = 0;
        if (it.op == ising_pkg::OP_WRITE)
        begin
            magnet += (it.spin_value ? 1 : -1) - old;
            spin_up[idx] = it.spin_value;
        end
        else
        begin
            s = spin_at(r, (c + 1) % SIDE) + spin_at(r, (c + SIDE - 1) % SIDE)
                + spin_at((r + SIDE - 1) % SIDE, c) + spin_at((r + 1) % SIDE, c);
            e = s * old;
            if (e < 0)
                accept = 1'b1;
            else
            begin
                th = (e == 0) ? thr_zero : (e == 2) ? thr_two : thr_four;
                accept = ({1'b0, it.random_draw} < th);
            end
            if (accept)
            begin
                spin_up[idx] = !spin_up[idx];
                magnet -= 2 * old;
            end
        end
        res.flipped = accept;
        res.spin_after = spin_up[idx];
        res.energy_change = ising_pkg::energy_t'(e);
        res.magnetization = ising_pkg::mag_t'(magnet);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // result check, then prediction of any item transferred at this edge
    always @(posedge clk)
    begin : scoreboard
        ising_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with no outstanding item");
                else
                begin
                    want = expected_q.pop_front();
                    if (result.flipped !== want.flipped)
                        report_mismatch($sformatf("flipped %0b, want %0b",
                            result.flipped, want.flipped));
                    if (result.spin_after !== want.spin_after)
                        report_mismatch($sformatf("spin_after %0b, want %0b",
                            result.spin_after, want.spin_after));
                    if (result.energy_change !== want.energy_change)
                        report_mismatch($sformatf("energy_change %0d, want %0d",
                            result.energy_change, want.energy_change));
                    if (result.magnetization !== want.magnetization)
                        report_mismatch($sformatf("magnetization %0d, want %0d",
                            result.magnetization, want.magnetization));
                end
            end
            if (start && !busy)
                expected_q.push_back(predict_update(item));
            if (cfg_write)
            begin
                case (cfg_index)
                    ising_pkg::CFG_THR_ZERO: thr_zero = cfg_data;
                    ising_pkg::CFG_THR_TWO:  thr_two = cfg_data;
                    ising_pkg::CFG_THR_FOUR: thr_four = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic ising_pkg::item_t make_item(logic op, int r, int c, int draw,
                                                   logic sv);
        ising_pkg::item_t it;
        it.op = op;
        it.row = ising_pkg::coord_t'(r);
        it.col = ising_pkg::coord_t'(c);
        it.random_draw = ising_pkg::draw_t'(draw);
        it.spin_value = sv;
        return it;
    endfunction

    // mostly a small window so that neighbours interact
    function automatic ising_pkg::item_t random_site_item();
        ising_pkg::item_t it;
        it.op = ($urandom_range(0, 99) < 30) ? ising_pkg::OP_WRITE : ising_pkg::OP_TRIAL;
        if ($urandom_range(0, 9) == 0)
        begin
            it.row = ising_pkg::coord_t'($urandom);
            it.col = ising_pkg::coord_t'($urandom);
        end
        else
        begin
            it.row = win_r + ising_pkg::coord_t'($urandom_range(0, 3));
            it.col = win_c + ising_pkg::coord_t'($urandom_range(0, 3));
        end
        case ($urandom_range(0, 7))
            0: it.random_draw = '0;
            1: it.random_draw = '1;
            default: it.random_draw = ising_pkg::draw_t'($urandom);
        endcase
        it.spin_value = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic ising_pkg::thr_t random_threshold();
        case ($urandom_range(0, 5))
            0: return ising_pkg::thr_t'(0);
            1: return ising_pkg::thr_t'(1);
            2: return ising_pkg::thr_t'(65535);
            3: return ising_pkg::thr_t'(65536);
            default: return ising_pkg::thr_t'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic lower_start();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 0;
        end
    endtask

    // one transfer, then burst/gap pacing
    task automatic send_item(ising_pkg::item_t it);
        int gap;
        item <= it;
        start <= 1'b1;
        start_high = 1;
        do @(posedge clk); while (busy);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                lower_start();
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic wait_idle();
        lower_start();
        do @(posedge clk); while (expected_q.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_thresholds(ising_pkg::thr_t z, ising_pkg::thr_t t,
                                    ising_pkg::thr_t f, ising_pkg::thr_t spare);
        cfg_write <= 1'b1;
        cfg_index <= ising_pkg::CFG_THR_ZERO;
        cfg_data <= z;
        @(posedge clk);
        cfg_index <= ising_pkg::CFG_THR_TWO;
        cfg_data <= t;
        @(posedge clk);
        cfg_index <= ising_pkg::CFG_THR_FOUR;
        cfg_data <= f;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data <= spare;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_window_items(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                win_r = ising_pkg::coord_t'($urandom);
                win_c = ising_pkg::coord_t'($urandom);
            end
            send_item(random_site_item());
        end
    endtask

    // reset thresholds, torus wrap at the corner, every sign of energy change
    task automatic test_directed_cases();
        wait_idle();
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 65535, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 43929, 1'b1));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 65535, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 43930, 1'b0));
        send_item(make_item(ising_pkg::OP_WRITE, 0, 0, 0, 1'b1));
        send_item(make_item(ising_pkg::OP_WRITE, 127, 127, 65535, 1'b0));
        send_item(make_item(ising_pkg::OP_WRITE, 0, 127, 0, 1'b0));
        send_item(make_item(ising_pkg::OP_WRITE, 127, 0, 12345, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 65535, 1'b1));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 65535, 1'b0));
        send_item(make_item(ising_pkg::OP_WRITE, 0, 1, 0, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 0, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 53656, 1'b1));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 53655, 1'b0));
        send_item(make_item(ising_pkg::OP_WRITE, 1, 0, 0, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 65535, 1'b0));
        send_item(make_item(ising_pkg::OP_TRIAL, 0, 0, 0, 1'b1));
        send_item(make_item(ising_pkg::OP_TRIAL, 127, 127, 12345, 1'b1));
        send_item(make_item(ising_pkg::OP_TRIAL, 127, 0, 65535, 1'b0));
        send_item(make_item(ising_pkg::OP_WRITE, 64, 64, 0, 1'b1));
        send_item(make_item(ising_pkg::OP_WRITE, 127, 127, 0, 1'b1));
        send_item(make_item(ising_pkg::OP_TRIAL, 64, 127, 65535, 1'b1));
        send_item(make_item(ising_pkg::OP_WRITE, 0, 127, 65535, 1'b1));
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        write_thresholds(ising_pkg::thr_t'(0), ising_pkg::thr_t'(0), ising_pkg::thr_t'(0),
            ising_pkg::thr_t'(17'h1FFFF));
        send_window_items(40);
        wait_idle();
        write_thresholds(ising_pkg::thr_t'(65536), ising_pkg::thr_t'(65536),
            ising_pkg::thr_t'(65536), ising_pkg::thr_t'(0));
        send_window_items(40);
        wait_idle();
        write_thresholds(ising_pkg::thr_t'(65535), ising_pkg::thr_t'(1), ising_pkg::thr_t'(0),
            ising_pkg::thr_t'(17'h10000));
        send_window_items(40);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            write_thresholds(random_threshold(), random_threshold(), random_threshold(),
                ising_pkg::thr_t'($urandom));
            send_window_items(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = ising_pkg::CFG_THR_ZERO;
        cfg_data = '0;
        foreach (spin_up[i])
            spin_up[i] = 1'b1;
        magnet = CELLS;
        thr_zero = ising_pkg::THR_ZERO_RST;
        thr_two = ising_pkg::THR_TWO_RST;
        thr_four = ising_pkg::THR_FOUR_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_threshold_extremes();
        test_random_phases();

        lower_start();
        do @(posedge clk); while (expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[ising_metropolis_spin_update.f]
hdl/ising_pkg.sv
hdl/ising_ctrl.sv
hdl/ising_dp.sv
hdl/ising_metropolis_spin_update.sv
verif/tb.sv
